>>> src/sfg_pkg.sv
// Package for the stream flush gate: widths, codes and the result record.
package sfg_pkg;

    localparam int ID_WIDTH        = 32;
    localparam int HANDLE_WIDTH    = 16;
    localparam int STREAM_ID_WIDTH = 32;

    // Request command codes
    typedef enum logic [1:0] {
        CMD_MESSAGE     = 2'd0,
        CMD_UNTIL_HALT  = 2'd1,
        CMD_UNTIL_FLUSH = 2'd2,
        CMD_UNUSED      = 2'd3
    } cmd_t;

    // Message kinds
    typedef enum logic [4:0] {
        KIND_MODE        = 5'd0,
        KIND_TRACK       = 5'd1,
        KIND_DRAIN       = 5'd2,
        KIND_DELAY       = 5'd3,
        KIND_ENCSTREAM   = 5'd4,
        KIND_AUDENC      = 5'd5,
        KIND_METATEXT    = 5'd6,
        KIND_INTERRUPTED = 5'd7,
        KIND_HALT        = 5'd8,
        KIND_FLUSH       = 5'd9,
        KIND_WAIT        = 5'd10,
        KIND_DECSTREAM   = 5'd11,
        KIND_BITRATE     = 5'd12,
        KIND_PCM         = 5'd13,
        KIND_SILENCE     = 5'd14,
        KIND_PLAYABLE    = 5'd15,
        KIND_QUIT        = 5'd16
    } kind_t;

    // Result types
    typedef enum logic [1:0] {
        RES_FORWARD = 2'd0,
        RES_STOP    = 2'd1,
        RES_ILLEGAL = 2'd2,
        RES_UNUSED  = 2'd3
    } res_type_t;

    // One result record
    typedef struct packed {
        logic [1:0]                 rtype;
        logic [4:0]                 kind;
        logic [HANDLE_WIDTH-1:0]    handle;
        logic [STREAM_ID_WIDTH-1:0] stream_id;
    } result_t;

endpackage

>>> src/stream_flush_gate_core.sv
// Stream flush gate: drops flushable messages while a halt or flush target is armed.
//
// Usage notes:
//   Input channel msg_valid / msg_stall carries one request: either a discard
//   command (arms a halt or flush target id) or one message of the stream.
//   Output channel res_valid / res_stall carries results: forwarded messages,
//   stop-and-release stream requests and illegal kind errors; out_last marks
//   the last result of a request.
//   The decision logic sits between the input handshake and the result register,
//   so a result is shown the cycle after its request is accepted.
//   Throughput is one request per cycle while the input is not stalled. A request
//   that also releases the held metatext gives two results; the second waits in
//   a pending register and the input stalls until it moves to the result register.
//   A request that gives no result (any command, or a dropped message) needs no
//   output slot.
//   When the receiver stalls, the result register holds its contents and the
//   input stalls too, unless the result register is free.
//   Reset clears all targets, seen ids, the held metatext and the valid flags of
//   both result registers; the block is ready as soon as reset is released.
module stream_flush_gate_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // request channel
    input  logic                                 msg_valid,
    output logic                                 msg_stall,
    input  logic [1:0]                           command,
    input  logic [4:0]                           msg_kind,
    input  logic [sfg_pkg::ID_WIDTH-1:0]         msg_id,
    input  logic                                 id_absent,
    input  logic                                 start_of_stream,
    input  logic [sfg_pkg::STREAM_ID_WIDTH-1:0]  stream_id,
    input  logic [sfg_pkg::HANDLE_WIDTH-1:0]     msg_handle,
    // result channel
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic [1:0]                           out_type,
    output logic [4:0]                           out_kind,
    output logic [sfg_pkg::HANDLE_WIDTH-1:0]     out_handle,
    output logic [sfg_pkg::STREAM_ID_WIDTH-1:0]  out_stream_id,
    output logic                                 out_last
);

    // gate state
    logic                                halt_armed_reg, halt_armed_next;
    logic [sfg_pkg::ID_WIDTH-1:0]        halt_target_reg, halt_target_next;
    logic                                flush_armed_reg, flush_armed_next;
    logic [sfg_pkg::ID_WIDTH-1:0]        flush_target_reg, flush_target_next;
    logic                                halt_seen_reg, halt_seen_next;
    logic [sfg_pkg::ID_WIDTH-1:0]        last_halt_reg, last_halt_next;
    logic                                flush_seen_reg, flush_seen_next;
    logic [sfg_pkg::ID_WIDTH-1:0]        last_flush_reg, last_flush_next;
    logic                                meta_held_reg, meta_held_next;
    logic [sfg_pkg::HANDLE_WIDTH-1:0]    meta_handle_reg, meta_handle_next;

    // result registers
    logic                                out_valid_reg, out_valid_next;
    sfg_pkg::result_t                    out_res_reg, out_res_next;
    logic                                out_last_reg, out_last_next;
    logic                                pend_valid_reg, pend_valid_next;
    logic [sfg_pkg::HANDLE_WIDTH-1:0]    pend_handle_reg, pend_handle_next;

    // decode outputs
    logic                                flushing;
    logic                                emit_main;
    sfg_pkg::result_t                    main_res;
    logic                                emit_meta;
    logic                                msg_accept;
    logic                                res_taken;

    assign res_taken  = out_valid_reg && !res_stall;
    assign msg_stall  = pend_valid_reg || (out_valid_reg && res_stall);
    assign msg_accept = msg_valid && !msg_stall;
    assign flushing   = halt_armed_reg || flush_armed_reg;

    // request decode and state update
    always_comb
    begin
        halt_armed_next   = halt_armed_reg;
        halt_target_next  = halt_target_reg;
        flush_armed_next  = flush_armed_reg;
        flush_target_next = flush_target_reg;
        halt_seen_next    = halt_seen_reg;
        last_halt_next    = last_halt_reg;
        flush_seen_next   = flush_seen_reg;
        last_flush_next   = last_flush_reg;
        meta_held_next    = meta_held_reg;
        meta_handle_next  = meta_handle_reg;
        emit_main         = 1'b0;
        main_res.rtype    = sfg_pkg::RES_FORWARD;
        main_res.kind     = msg_kind;
        main_res.handle   = msg_handle;
        main_res.stream_id = '0;

        unique case (command)
            sfg_pkg::CMD_UNTIL_HALT:
            begin
                if (!halt_seen_reg || (last_halt_reg < msg_id))
                begin
                    halt_armed_next  = 1'b1;
                    halt_target_next = msg_id;
                end
            end
            sfg_pkg::CMD_UNTIL_FLUSH:
            begin
                if (!flush_seen_reg || (last_flush_reg < msg_id))
                begin
                    flush_armed_next  = 1'b1;
                    flush_target_next = msg_id;
                end
            end
            sfg_pkg::CMD_MESSAGE:
            begin
                unique case (msg_kind) inside
                    sfg_pkg::KIND_MODE, sfg_pkg::KIND_DRAIN,
                    sfg_pkg::KIND_DELAY, sfg_pkg::KIND_QUIT:
                    begin
                        emit_main = 1'b1;
                    end
                    sfg_pkg::KIND_TRACK:
                    begin
                        // a new stream makes the held metatext stale
                        if (flushing && start_of_stream)
                            meta_held_next = 1'b0;
                        emit_main = !flushing;
                    end
                    sfg_pkg::KIND_ENCSTREAM, sfg_pkg::KIND_INTERRUPTED,
                    sfg_pkg::KIND_WAIT, sfg_pkg::KIND_BITRATE,
                    sfg_pkg::KIND_PCM, sfg_pkg::KIND_SILENCE:
                    begin
                        emit_main = !flushing;
                    end
                    sfg_pkg::KIND_METATEXT:
                    begin
                        if (flushing)
                        begin
                            meta_held_next   = 1'b1;
                            meta_handle_next = msg_handle;
                        end
                        emit_main = !flushing;
                    end
                    sfg_pkg::KIND_HALT:
                    begin
                        if (!id_absent)
                        begin
                            halt_seen_next = 1'b1;
                            last_halt_next = msg_id;
                            if (halt_armed_reg && (halt_target_reg == msg_id))
                                halt_armed_next = 1'b0;
                        end
                        emit_main = 1'b1;
                    end
                    sfg_pkg::KIND_FLUSH:
                    begin
                        if (!id_absent)
                        begin
                            flush_seen_next = 1'b1;
                            last_flush_next = msg_id;
                            if (flush_armed_reg && (flush_target_reg == msg_id))
                                flush_armed_next = 1'b0;
                        end
                        emit_main = 1'b1;
                    end
                    sfg_pkg::KIND_DECSTREAM:
                    begin
                        // dropped stream becomes a stop-and-release request
                        if (flushing)
                        begin
                            main_res.rtype     = sfg_pkg::RES_STOP;
                            main_res.kind      = sfg_pkg::KIND_DECSTREAM;
                            main_res.handle    = '0;
                            main_res.stream_id = stream_id;
                        end
                        emit_main = 1'b1;
                    end
                    default:
                    begin
                        main_res.rtype = sfg_pkg::RES_ILLEGAL;
                        emit_main      = 1'b1;
                    end
                endcase
            end
            default:
            begin
                // unused command code: ignored
            end
        endcase

        // release the held metatext once nothing is armed
        emit_meta = !halt_armed_next && !flush_armed_next && meta_held_next;
        if (emit_meta)
            meta_held_next = 1'b0;
    end

    // result register loading
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_res_next     = out_res_reg;
        out_last_next    = out_last_reg;
        pend_valid_next  = pend_valid_reg;
        pend_handle_next = pend_handle_reg;

        if (res_taken)
        begin
            // pending metatext moves up, or the slot empties
            out_valid_next = pend_valid_reg;
            out_res_next.rtype     = sfg_pkg::RES_FORWARD;
            out_res_next.kind      = sfg_pkg::KIND_METATEXT;
            out_res_next.handle    = pend_handle_reg;
            out_res_next.stream_id = '0;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end

        if (msg_accept)
        begin
            if (emit_main)
            begin
                out_valid_next   = 1'b1;
                out_res_next     = main_res;
                out_last_next    = !emit_meta;
                pend_valid_next  = emit_meta;
                pend_handle_next = meta_handle_next;
            end
            else if (emit_meta)
            begin
                out_valid_next         = 1'b1;
                out_res_next.rtype     = sfg_pkg::RES_FORWARD;
                out_res_next.kind      = sfg_pkg::KIND_METATEXT;
                out_res_next.handle    = meta_handle_next;
                out_res_next.stream_id = '0;
                out_last_next          = 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_armed_reg   <= 1'b0;
            halt_target_reg  <= '0;
            flush_armed_reg  <= 1'b0;
            flush_target_reg <= '0;
            halt_seen_reg    <= 1'b0;
            last_halt_reg    <= '0;
            flush_seen_reg   <= 1'b0;
            last_flush_reg   <= '0;
            meta_held_reg    <= 1'b0;
            meta_handle_reg  <= '0;
        end
        else if (msg_accept)
        begin
            halt_armed_reg   <= halt_armed_next;
            halt_target_reg  <= halt_target_next;
            flush_armed_reg  <= flush_armed_next;
            flush_target_reg <= flush_target_next;
            halt_seen_reg    <= halt_seen_next;
            last_halt_reg    <= last_halt_next;
            flush_seen_reg   <= flush_seen_next;
            last_flush_reg   <= last_flush_next;
            meta_held_reg    <= meta_held_next;
            meta_handle_reg  <= meta_handle_next;
        end
    end

    // result control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_last_reg   <= out_last_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        out_res_reg     <= out_res_next;
        pend_handle_reg <= pend_handle_next;
    end

    assign res_valid     = out_valid_reg;
    assign out_type      = out_res_reg.rtype;
    assign out_kind      = out_res_reg.kind;
    assign out_handle    = out_res_reg.handle;
    assign out_stream_id = out_res_reg.stream_id;
    assign out_last      = out_last_reg;

    // pending metatext only sits behind a shown result
    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (out_valid_reg && !out_last_reg))
        else $error("pending result without a non-last result in front");

    // input is held off while a second result waits
    a_pend_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> msg_stall)
        else $error("request accepted while second result pending");

    // pending result follows as the last metatext
    a_pend_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (res_taken && pend_valid_reg) |=>
            (res_valid && out_last && (out_kind == sfg_pkg::KIND_METATEXT)
             && (out_type == sfg_pkg::RES_FORWARD)))
        else $error("pending metatext not presented after handover");

    // metatext is never held while nothing is armed
    a_meta_only_flushing: assert property (@(posedge clk) disable iff (!rst_n)
        meta_held_reg |-> flushing)
        else $error("metatext held with no target armed");

endmodule
